// ----- src/mtep_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_pkg
// Codes and helpers shared by the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    // Longest variable-length number, in bytes
    localparam int unsigned MaxNumberBytes = 4;

    localparam int unsigned DataByteW = 8;
    localparam int unsigned TickW     = 32;
    localparam int unsigned RoleW     = 3;
    localparam int unsigned ErrW      = 2;
    localparam int unsigned ChanW     = 4;

    // Output stream packing
    localparam int unsigned OutDataW = 56;
    localparam int unsigned OutUserW = 4;

    // Byte roles
    localparam logic [RoleW-1:0] RoleDelta    = 3'd0;
    localparam logic [RoleW-1:0] RoleStatus   = 3'd1;
    localparam logic [RoleW-1:0] RoleMetaType = 3'd2;
    localparam logic [RoleW-1:0] RoleLength   = 3'd3;
    localparam logic [RoleW-1:0] RolePayload  = 3'd4;
    localparam logic [RoleW-1:0] RoleIgnored  = 3'd5;

    // Error codes
    localparam logic [ErrW-1:0] ErrNone        = 2'd0;
    localparam logic [ErrW-1:0] ErrOverlong    = 2'd1;
    localparam logic [ErrW-1:0] ErrRunningStat = 2'd2;

    // Status and meta type codes
    localparam logic [7:0] StatMeta        = 8'hFF;
    localparam logic [7:0] StatSysex       = 8'hF0;
    localparam logic [7:0] StatSysexEscape = 8'hF7;
    localparam logic [7:0] StatSongPos     = 8'hF2;
    localparam logic [7:0] StatSongSelect  = 8'hF3;
    localparam logic [7:0] MetaEndOfTrack  = 8'h2F;
    localparam logic [7:0] StatNoteOff     = 8'h80;
    localparam logic [7:0] StatNoteOn      = 8'h90;
    localparam logic [7:0] StatKeyPress    = 8'hA0;
    localparam logic [7:0] StatControl     = 8'hB0;
    localparam logic [7:0] StatPitchWheel  = 8'hE0;

    // Channel messages that carry two data bytes
    function automatic logic is_two_byte(input logic [7:0] t);
        return (t == StatNoteOff) || (t == StatNoteOn) || (t == StatKeyPress) ||
               (t == StatControl) || (t == StatPitchWheel);
    endfunction

endpackage
`default_nettype wire

// ----- src/midi_track_event_parser_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// midi_track_event_parser_top
// Parses MIDI track body bytes, tagging each byte with its role and tracking
// tick position, running status and event boundaries.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata                      | tuser               | tlast
// s       | in  | data_byte                  | track_start         | -
// m       | out | tick, type, chan, payload, | byte_role, is_meta  | event_done
//         |     | track_end, error_code      |                     |
//
// One item in, one item out; an item is accepted every cycle while the result
// register is empty or being drained. The result appears in the cycle after the
// byte is taken, held in the single result register after the decode logic.
// Reset (synchronous, active low) clears parser state and the result valid.
// A stalled result holds; input is taken only when the result register frees.
// ----------------------------------------------------------------------------
module midi_track_event_parser_top #(
    parameter int unsigned MAX_NUMBER_BYTES = mtep_pkg::MaxNumberBytes
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [mtep_pkg::DataByteW-1:0] i_s_tdata,  // [7:0] data_byte
    input  wire logic [0:0]                    i_s_tuser,   // [0] track_start
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [31:0] tick_position, [39:32] event_type, [43:40] channel,
    // [51:44] payload_byte, [52] track_end, [54:53] error_code, [55] zero
    output logic [mtep_pkg::OutDataW-1:0]      o_m_tdata,
    // [2:0] byte_role, [3] is_meta
    output logic [mtep_pkg::OutUserW-1:0]      o_m_tuser,
    output logic                               o_m_tlast    // event_done
);

    localparam int unsigned AccW =
        (7 * MAX_NUMBER_BYTES > 32) ? 32 : 7 * MAX_NUMBER_BYTES;
    localparam int unsigned CntW = $clog2(MAX_NUMBER_BYTES + 1);

    typedef enum logic [2:0] {
        PH_DELTA    = 3'd0,
        PH_STATUS   = 3'd1,
        PH_METATYPE = 3'd2,
        PH_LENGTH   = 3'd3,
        PH_PAYLOAD  = 3'd4
    } t_phase;

    // Parser state
    t_phase                           r_phase, n_phase;
    logic [AccW-1:0]                  r_acc, n_acc;
    logic [CntW-1:0]                  r_cnt, n_cnt;
    logic [mtep_pkg::TickW-1:0]       r_pos, n_pos;
    logic [7:0]                       r_type, n_type;
    logic                             r_meta, n_meta;
    logic [mtep_pkg::ChanW-1:0]       r_chan, n_chan;
    logic [AccW-1:0]                  r_rem, n_rem;
    logic                             r_halted, n_halted;

    // Result register
    logic                             r_out_valid;
    logic [mtep_pkg::RoleW-1:0]       r_role, n_role;
    logic [7:0]                       r_payload, n_payload;
    logic                             r_done, n_done;
    logic                             r_tend, n_tend;
    logic [mtep_pkg::ErrW-1:0]        r_err, n_err;

    logic [AccW-1:0]                  acc_sh;
    logic [CntW-1:0]                  cnt_inc;
    logic [AccW-1:0]                  rem_dec;
    logic [7:0]                       byte_in;
    logic                             s_accept;

    assign byte_in    = i_s_tdata;
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_type    = r_type;
        n_meta    = r_meta;
        n_chan    = r_chan;
        n_rem     = r_rem;
        n_halted  = r_halted;
        n_role    = mtep_pkg::RoleIgnored;
        n_payload = '0;
        n_done    = 1'b0;
        n_tend    = 1'b0;
        n_err     = mtep_pkg::ErrNone;
        acc_sh    = '0;
        cnt_inc   = '0;
        rem_dec   = '0;

        // Track start clears everything but the channel before the byte is parsed
        if (i_s_tuser[0]) begin
            n_phase  = PH_DELTA;
            n_acc    = '0;
            n_cnt    = '0;
            n_pos    = '0;
            n_type   = mtep_pkg::StatMeta;
            n_meta   = 1'b0;
            n_rem    = '0;
            n_halted = 1'b0;
        end

        acc_sh  = AccW'({n_acc, byte_in[6:0]});
        cnt_inc = n_cnt + CntW'(1);

        if (!n_halted) begin
            unique case (n_phase)
                PH_DELTA: begin
                    n_role = mtep_pkg::RoleDelta;
                    if (!byte_in[7]) begin
                        n_pos   = n_pos + mtep_pkg::TickW'(acc_sh);
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_phase = PH_STATUS;
                    end else begin
                        n_acc = acc_sh;
                        n_cnt = cnt_inc;
                        if (cnt_inc >= CntW'(MAX_NUMBER_BYTES)) begin
                            n_err    = mtep_pkg::ErrOverlong;
                            n_halted = 1'b1;
                        end
                    end
                end
                PH_STATUS: begin
                    if (!byte_in[7]) begin
                        // Running status: legal only after a channel message
                        if (n_meta || !n_type[7] || (n_type[7:4] == 4'hF)) begin
                            n_role   = mtep_pkg::RoleStatus;
                            n_err    = mtep_pkg::ErrRunningStat;
                            n_halted = 1'b1;
                        end else begin
                            n_role    = mtep_pkg::RolePayload;
                            n_payload = byte_in;
                            if (mtep_pkg::is_two_byte(n_type)) begin
                                n_rem   = AccW'(1);
                                n_phase = PH_PAYLOAD;
                            end else begin
                                n_rem   = '0;
                                n_done  = 1'b1;
                                n_phase = PH_DELTA;
                            end
                        end
                    end else begin
                        n_role = mtep_pkg::RoleStatus;
                        n_meta = 1'b0;
                        if (byte_in[7:4] != 4'hF) begin
                            n_chan  = byte_in[3:0];
                            n_type  = {byte_in[7:4], 4'h0};
                            n_rem   = mtep_pkg::is_two_byte({byte_in[7:4], 4'h0})
                                      ? AccW'(2) : AccW'(1);
                            n_phase = PH_PAYLOAD;
                        end else begin
                            n_type = byte_in;
                            n_acc  = '0;
                            n_cnt  = '0;
                            if (byte_in == mtep_pkg::StatMeta) begin
                                n_phase = PH_METATYPE;
                            end else if ((byte_in == mtep_pkg::StatSysex) ||
                                         (byte_in == mtep_pkg::StatSysexEscape)) begin
                                n_phase = PH_LENGTH;
                            end else if (byte_in == mtep_pkg::StatSongPos) begin
                                n_rem   = AccW'(2);
                                n_phase = PH_PAYLOAD;
                            end else if (byte_in == mtep_pkg::StatSongSelect) begin
                                n_rem   = AccW'(1);
                                n_phase = PH_PAYLOAD;
                            end else begin
                                n_rem   = '0;
                                n_done  = 1'b1;
                                n_phase = PH_DELTA;
                            end
                        end
                    end
                end
                PH_METATYPE: begin
                    n_role  = mtep_pkg::RoleMetaType;
                    n_type  = byte_in;
                    n_meta  = 1'b1;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    n_role = mtep_pkg::RoleLength;
                    if (!byte_in[7]) begin
                        n_rem = acc_sh;
                        n_acc = '0;
                        n_cnt = '0;
                        if (acc_sh == '0) begin
                            n_done  = 1'b1;
                            n_phase = PH_DELTA;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_acc = acc_sh;
                        n_cnt = cnt_inc;
                        if (cnt_inc >= CntW'(MAX_NUMBER_BYTES)) begin
                            n_err    = mtep_pkg::ErrOverlong;
                            n_halted = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_role    = mtep_pkg::RolePayload;
                    n_payload = byte_in;
                    rem_dec   = (n_rem != '0) ? n_rem - AccW'(1) : '0;
                    n_rem     = rem_dec;
                    if (rem_dec == '0) begin
                        n_done  = 1'b1;
                        n_phase = PH_DELTA;
                    end
                end
                default: begin
                    n_phase = PH_DELTA;
                end
            endcase

            // End of track halts until the next track start
            if (n_done && n_meta && (n_type == mtep_pkg::MetaEndOfTrack)) begin
                n_tend   = 1'b1;
                n_halted = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DELTA;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_type      <= mtep_pkg::StatMeta;
            r_meta      <= 1'b0;
            r_chan      <= '0;
            r_rem       <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_phase   <= n_phase;
                r_acc     <= n_acc;
                r_cnt     <= n_cnt;
                r_pos     <= n_pos;
                r_type    <= n_type;
                r_meta    <= n_meta;
                r_chan    <= n_chan;
                r_rem     <= n_rem;
                r_halted  <= n_halted;
                r_role    <= n_role;
                r_payload <= n_payload;
                r_done    <= n_done;
                r_tend    <= n_tend;
                r_err     <= n_err;
            end
            if (s_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_err, r_tend, r_payload, r_chan, r_type, r_pos};
    assign o_m_tuser  = {r_meta, r_role};
    assign o_m_tlast  = r_done;

    // Payload phase always has bytes left to take
    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_rem != '0))
        else $error("payload phase with no bytes remaining");

    // An error or end of track halts the parser
    a_halt_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && ((n_err != mtep_pkg::ErrNone) || n_tend)) |=> r_halted)
        else $error("parser not halted after error or end of track");

    // End of track only closes an end-of-track meta event
    a_tend_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_tend) |->
        (r_done && r_meta && (r_type == mtep_pkg::MetaEndOfTrack)))
        else $error("track end outside an end-of-track meta event");

    // An error byte never closes an event, payload value only on payload bytes
    a_err_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_err != mtep_pkg::ErrNone)) |-> (!r_done && !r_tend))
        else $error("error item marked as event end");

    a_payload_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_role != mtep_pkg::RolePayload)) |-> (r_payload == '0))
        else $error("payload value on a non-payload item");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Streams track body bytes into the parser and checks every result item
// against a local model. The model tracks delta time, running status,
// data lengths and the halt after errors or end of track. The stimulus is a
// short directed sequence, then random tracks, mostly well formed, with some
// broken ones. Each segment of the random run uses one of four patterns of idle
// and stall cycles on the two stream interfaces, in turn.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned DrainCycles   = 10;
    localparam int unsigned RandomItems   = 1750;
    localparam int unsigned SegmentItems  = 220;

    typedef enum logic [2:0] {
        PhDelta, PhStatus, PhMetaType, PhLength, PhPayload
    } t_parse_phase;

    typedef enum logic [1:0] {NumMore, NumDone, NumOverlong} t_number_state;

    typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} t_idle_mode;

    typedef struct {
        logic [7:0] data;
        logic       start;
        t_idle_mode mode;
        logic       drain_first;
    } t_track_byte;

    typedef struct {
        logic [mtep_pkg::RoleW-1:0] role;
        logic [mtep_pkg::TickW-1:0] tick;
        logic [7:0]                 etype;
        logic                       is_meta;
        logic [mtep_pkg::ChanW-1:0] chan;
        logic [7:0]                 payload;
        logic                       done;
        logic                       tend;
        logic [mtep_pkg::ErrW-1:0]  err;
    } t_parse_result;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic [7:0]                    i_s_tdata  = '0;
    logic [0:0]                    i_s_tuser  = '0;
    logic                          i_m_tready = 1'b0;
    logic                          o_s_tready;
    logic                          o_m_tvalid;
    logic [mtep_pkg::OutDataW-1:0] o_m_tdata;
    logic [mtep_pkg::OutUserW-1:0] o_m_tuser;
    logic                          o_m_tlast;

    midi_track_event_parser_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] data_byte
        .i_s_tuser  (i_s_tuser),   // [0] track_start
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // tick, type, channel, payload, track_end, error
        .o_m_tuser  (o_m_tuser),   // [2:0] byte_role, [3] is_meta
        .o_m_tlast  (o_m_tlast)    // event_done
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_track_byte   pending_items[$];
    t_parse_result expected_results[$];
    t_track_byte   cur_item;
    t_idle_mode    cur_mode     = IdleNone;
    logic          s_accepted   = 1'b0;
    int unsigned   stuck_cycles = 0;
    int unsigned   fail_count   = 0;

    // Stimulus generator state
    t_idle_mode gen_mode       = IdleNone;
    logic       gen_drain      = 1'b0;
    logic       gen_start      = 1'b0;
    logic       gen_running_ok = 1'b0;
    logic [7:0] gen_last_type  = '0;

    // Parser model state
    t_parse_phase ps_phase;
    logic [31:0]  ps_acc;
    logic [31:0]  ps_count;
    logic [31:0]  ps_position;
    logic [31:0]  ps_remaining;
    logic [7:0]   ps_type;
    logic         ps_meta;
    logic [3:0]   ps_chan;
    logic         ps_halted;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic logic [31:0] channel_data_count(input logic [7:0] t);
        case (t)
            mtep_pkg::StatNoteOff, mtep_pkg::StatNoteOn, mtep_pkg::StatKeyPress,
            mtep_pkg::StatControl, mtep_pkg::StatPitchWheel: return 2;
            default: return 1;
        endcase
    endfunction

    function automatic t_number_state feed_number(input logic [7:0] b);
        ps_acc = (ps_acc << 7) | {25'd0, b[6:0]};
        if (!b[7]) return NumDone;
        ps_count = ps_count + 1;
        if (ps_count >= mtep_pkg::MaxNumberBytes) return NumOverlong;
        return NumMore;
    endfunction

    function automatic logic [31:0] system_data_count(input logic [7:0] b);
        if (b == mtep_pkg::StatSongPos) return 2;
        if (b == mtep_pkg::StatSongSelect) return 1;
        return 0;
    endfunction

    function automatic t_parse_result parse_byte(input logic [7:0] b, input logic start);
        t_parse_result r;
        t_number_state ns;
        r.role    = mtep_pkg::RoleIgnored;
        r.payload = '0;
        r.done    = 1'b0;
        r.tend    = 1'b0;
        r.err     = mtep_pkg::ErrNone;
        // Track start clears everything but the channel
        if (start) begin
            ps_phase     = PhDelta;
            ps_acc       = '0;
            ps_count     = '0;
            ps_position  = '0;
            ps_type      = mtep_pkg::StatMeta;
            ps_meta      = 1'b0;
            ps_remaining = '0;
            ps_halted    = 1'b0;
        end
        if (!ps_halted) begin
            case (ps_phase)
                PhDelta: begin
                    r.role = mtep_pkg::RoleDelta;
                    ns = feed_number(b);
                    if (ns == NumDone) begin
                        ps_position = ps_position + ps_acc;
                        ps_acc      = '0;
                        ps_count    = '0;
                        ps_phase    = PhStatus;
                    end else if (ns == NumOverlong) begin
                        r.err     = mtep_pkg::ErrOverlong;
                        ps_halted = 1'b1;
                    end
                end
                PhStatus: begin
                    if (!b[7]) begin
                        // Running status needs a channel message before it
                        if (ps_meta || !ps_type[7] || ps_type >= mtep_pkg::StatSysex) begin
                            r.role    = mtep_pkg::RoleStatus;
                            r.err     = mtep_pkg::ErrRunningStat;
                            ps_halted = 1'b1;
                        end else begin
                            r.role       = mtep_pkg::RolePayload;
                            r.payload    = b;
                            ps_remaining = channel_data_count(ps_type) - 1;
                            if (ps_remaining == 0) begin
                                r.done   = 1'b1;
                                ps_phase = PhDelta;
                            end else begin
                                ps_phase = PhPayload;
                            end
                        end
                    end else begin
                        r.role  = mtep_pkg::RoleStatus;
                        ps_meta = 1'b0;
                        if (b < mtep_pkg::StatSysex) begin
                            ps_chan      = b[3:0];
                            ps_type      = {b[7:4], 4'h0};
                            ps_remaining = channel_data_count(ps_type);
                            ps_phase     = PhPayload;
                        end else begin
                            ps_type  = b;
                            ps_acc   = '0;
                            ps_count = '0;
                            if (b == mtep_pkg::StatMeta) begin
                                ps_phase = PhMetaType;
                            end else if (b == mtep_pkg::StatSysex ||
                                         b == mtep_pkg::StatSysexEscape) begin
                                ps_phase = PhLength;
                            end else begin
                                ps_remaining = system_data_count(b);
                                if (ps_remaining == 0) begin
                                    r.done   = 1'b1;
                                    ps_phase = PhDelta;
                                end else begin
                                    ps_phase = PhPayload;
                                end
                            end
                        end
                    end
                end
                PhMetaType: begin
                    r.role   = mtep_pkg::RoleMetaType;
                    ps_type  = b;
                    ps_meta  = 1'b1;
                    ps_acc   = '0;
                    ps_count = '0;
                    ps_phase = PhLength;
                end
                PhLength: begin
                    r.role = mtep_pkg::RoleLength;
                    ns = feed_number(b);
                    if (ns == NumDone) begin
                        ps_remaining = ps_acc;
                        ps_acc       = '0;
                        ps_count     = '0;
                        if (ps_remaining == 0) begin
                            r.done   = 1'b1;
                            ps_phase = PhDelta;
                        end else begin
                            ps_phase = PhPayload;
                        end
                    end else if (ns == NumOverlong) begin
                        r.err     = mtep_pkg::ErrOverlong;
                        ps_halted = 1'b1;
                    end
                end
                default: begin
                    r.role    = mtep_pkg::RolePayload;
                    r.payload = b;
                    if (ps_remaining != 0) ps_remaining = ps_remaining - 1;
                    if (ps_remaining == 0) begin
                        r.done   = 1'b1;
                        ps_phase = PhDelta;
                    end
                end
            endcase
            if (r.done && ps_meta && ps_type == mtep_pkg::MetaEndOfTrack) begin
                r.tend    = 1'b1;
                ps_halted = 1'b1;
            end
        end
        r.tick    = ps_position;
        r.etype   = ps_type;
        r.is_meta = ps_meta;
        r.chan    = ps_chan;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        t_track_byte t;
        t.data        = b;
        t.start       = gen_start;
        t.mode        = gen_mode;
        t.drain_first = gen_drain;
        gen_start     = 1'b0;
        gen_drain     = 1'b0;
        pending_items.push_back(t);
    endtask

    // Encode as a variable-length number, optionally with leading pad groups
    task automatic push_number(input logic [27:0] value, input int pad);
        logic [31:0] v;
        int n;
        int total;
        v = {4'd0, value};
        n = 1;
        while (n < 4 && (v >> (7 * n)) != 0) n++;
        total = n + pad;
        if (total > int'(mtep_pkg::MaxNumberBytes)) total = int'(mtep_pkg::MaxNumberBytes);
        for (int i = total - 1; i >= 0; i--) push_byte({i != 0, 7'(v >> (7 * i))});
    endtask

    function automatic logic [27:0] random_delta();
        case ($urandom_range(19))
            0, 1, 2:    return 28'($urandom & 32'h0FFF_FFFF);
            3, 4, 5, 6: return 28'($urandom_range(16383));
            7:          return '0;
            default:    return 28'($urandom_range(127));
        endcase
    endfunction

    function automatic logic [27:0] random_length();
        case ($urandom_range(19))
            0, 1, 2: return '0;
            19:      return 28'($urandom_range(300, 100));
            default: return 28'($urandom_range(6, 1));
        endcase
    endfunction

    task automatic push_delta();
        push_number(random_delta(), ($urandom_range(9) == 0) ? 1 : 0);
    endtask

    task automatic push_channel_data(input logic [31:0] count);
        for (int i = 0; i < count; i++)
            push_byte(($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(127)));
    endtask

    task automatic push_sized_body();
        logic [27:0] len;
        len = random_length();
        push_number(len, ($urandom_range(9) == 0) ? 1 : 0);
        for (int i = 0; i < len; i++) push_byte(8'($urandom_range(255)));
    endtask

    task automatic push_random_event();
        int unsigned pick;
        logic [7:0] st;
        pick = $urandom_range(99);
        push_delta();
        if (pick < 55) begin
            if (pick >= 35 && gen_running_ok) begin
                push_channel_data(channel_data_count(gen_last_type));
            end else begin
                st = 8'($urandom_range(8'hEF, 8'h80));
                push_byte(st);
                gen_last_type  = {st[7:4], 4'h0};
                gen_running_ok = 1'b1;
                push_channel_data(channel_data_count(gen_last_type));
            end
        end else if (pick < 70) begin
            push_byte(mtep_pkg::StatMeta);
            st = 8'($urandom_range(255));
            push_byte((st == mtep_pkg::MetaEndOfTrack) ? 8'h01 : st);
            push_sized_body();
            gen_running_ok = 1'b0;
        end else if (pick < 82) begin
            push_byte($urandom_range(1) ? mtep_pkg::StatSysex : mtep_pkg::StatSysexEscape);
            push_sized_body();
            gen_running_ok = 1'b0;
        end else begin
            st = 8'($urandom_range(8'hFE, 8'hF1));
            if (st == mtep_pkg::StatSysexEscape) st = mtep_pkg::StatSongPos;
            push_byte(st);
            push_channel_data(system_data_count(st));
            gen_running_ok = 1'b0;
        end
    endtask

    task automatic push_noise(input int unsigned max_count);
        int unsigned count;
        count = $urandom_range(max_count);
        for (int i = 0; i < count; i++) push_byte(8'($urandom_range(255)));
    endtask

    // Broken events: errors, noise or an event cut off by a track start, then random bytes
    task automatic push_broken_event();
        case ($urandom_range(4))
            0: begin
                for (int i = 0; i < mtep_pkg::MaxNumberBytes; i++)
                    push_byte(8'($urandom_range(255, 128)));
            end
            1: begin
                push_delta();
                push_byte(mtep_pkg::StatSysex);
                push_byte(8'h00);
                push_delta();
                push_byte(8'($urandom_range(127)));
            end
            2: begin
                push_delta();
                if ($urandom_range(1)) begin
                    push_byte(mtep_pkg::StatMeta);
                    push_byte(8'($urandom_range(255)));
                end else begin
                    push_byte(mtep_pkg::StatSysex);
                end
                for (int i = 0; i < mtep_pkg::MaxNumberBytes; i++)
                    push_byte(8'($urandom_range(255, 128)));
            end
            3: begin
                push_noise(8);
            end
            default: begin
                // Cut off by the next track start
                push_delta();
                push_byte(8'($urandom_range(8'hEF, 8'h80)));
                push_channel_data($urandom_range(1));
            end
        endcase
        push_noise(3);
    endtask

    task automatic push_random_track();
        int unsigned n_events;
        gen_start      = 1'b1;
        gen_running_ok = 1'b0;
        n_events       = $urandom_range(10, 1);
        for (int e = 0; e < n_events; e++) begin
            if ($urandom_range(99) < 6) begin
                push_broken_event();
                return;
            end
            push_random_event();
        end
        if ($urandom_range(9) < 6) begin
            push_delta();
            push_byte(mtep_pkg::StatMeta);
            push_byte(mtep_pkg::MetaEndOfTrack);
            if ($urandom_range(4) == 0) begin
                push_sized_body();
            end else begin
                push_byte(8'h00);
            end
            push_noise(3);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic check_result(input t_parse_result exp);
        compare_field("byte_role",     32'(exp.role),    32'(o_m_tuser[2:0]));
        compare_field("is_meta",       32'(exp.is_meta), 32'(o_m_tuser[3]));
        compare_field("tick_position", exp.tick,         o_m_tdata[31:0]);
        compare_field("event_type",    32'(exp.etype),   32'(o_m_tdata[39:32]));
        compare_field("channel",       32'(exp.chan),    32'(o_m_tdata[43:40]));
        compare_field("payload_byte",  32'(exp.payload), 32'(o_m_tdata[51:44]));
        compare_field("track_end",     32'(exp.tend),    32'(o_m_tdata[52]));
        compare_field("error_code",    32'(exp.err),     32'(o_m_tdata[54:53]));
        compare_field("event_done",    32'(exp.done),    32'(o_m_tlast));
    endtask

    function automatic int unsigned sender_idle_pct(input t_idle_mode m);
        case (m)
            IdleSender: return 56;
            IdleBoth:   return 11;
            default:    return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct(input t_idle_mode m);
        case (m)
            IdleReceiver: return 56;
            IdleBoth:     return 11;
            default:      return 0;
        endcase
    endfunction

    // Outputs first, then record the accepted input item, so that results
    // never meet an expectation pushed at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= WatchdogLimit) begin
                $display("%0t: no handshake for %0d cycles", $time, stuck_cycles);
                $display("Simulation FAILED");
                $finish;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result item with nothing expected: tdata %h tuser %h",
                             $time, o_m_tdata, o_m_tuser);
                    fail_count++;
                end else begin
                    check_result(expected_results.pop_front());
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(parse_byte(i_s_tdata, i_s_tuser[0]));
                s_accepted = 1'b1;
            end
        end
    end

    // Driver: hold an item until taken, then idle or present the next one
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_tvalid || s_accepted) begin
                s_accepted = 1'b0;
                if (pending_items.size() == 0 ||
                    (pending_items[0].drain_first && expected_results.size() != 0) ||
                    $urandom_range(99) < sender_idle_pct(pending_items[0].mode)) begin
                    i_s_tvalid <= 1'b0;
                end else begin
                    cur_item = pending_items.pop_front();
                    cur_mode = cur_item.mode;
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= cur_item.data;
                    i_s_tuser  <= cur_item.start;
                end
            end
            i_m_tready <= ($urandom_range(99) >= receiver_stall_pct(cur_mode));
        end
    end

    initial begin
        int unsigned seg;
        int unsigned next_switch;
        int unsigned directed_size;

        ps_phase     = PhDelta;
        ps_acc       = '0;
        ps_count     = '0;
        ps_position  = '0;
        ps_remaining = '0;
        ps_type      = mtep_pkg::StatMeta;
        ps_meta      = 1'b0;
        ps_chan      = '0;
        ps_halted    = 1'b0;

        // Note on with data extremes, then running status after a two-byte delta
        gen_start = 1'b1;
        push_byte(8'h00); push_byte(mtep_pkg::StatNoteOn); push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h81); push_byte(8'h7F); push_byte(8'h40); push_byte(8'h40);
        // Zero-length meta, then end of track and a dropped byte
        push_byte(8'h00); push_byte(mtep_pkg::StatMeta); push_byte(8'h01); push_byte(8'h00);
        push_byte(8'h00); push_byte(mtep_pkg::StatMeta);
        push_byte(mtep_pkg::MetaEndOfTrack); push_byte(8'h00);
        push_byte(8'h55);
        // Largest delta, then running status with no channel message yet
        gen_start = 1'b1;
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h7F);
        push_byte(8'h40);
        // Delta one byte too long
        gen_start = 1'b1;
        push_byte(8'h80); push_byte(8'h80); push_byte(8'h80); push_byte(8'h80);
        directed_size = pending_items.size();

        seg         = 0;
        next_switch = directed_size;
        while (pending_items.size() < directed_size + RandomItems) begin
            if (pending_items.size() >= next_switch) begin
                gen_mode    = t_idle_mode'(seg % 4);
                gen_drain   = 1'b1;
                seg++;
                next_switch = next_switch + SegmentItems;
            end
            push_random_track();
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Poll at the rising edge, where the driver's queue and valid are settled
        while (pending_items.size() != 0 || i_s_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/mtep_pkg.sv
src/midi_track_event_parser_top.sv
sim/testbench.sv
